### rtl/core/tcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the text command light controller.
// ----------------------------------------------------------------------------
package tcl_pkg;

    localparam int unsigned WINDOW      = 14;
    localparam int unsigned NUM_PHRASES = 9;
    localparam int unsigned NUM_LIGHTS  = 3;
    localparam int unsigned THR_W       = 11;
    localparam int unsigned SAMPLE_W    = 10;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd308;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CASE_STEP = 8'h20;

    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_RECOG   = 2'd1;
    localparam logic [1:0] OUTCOME_UNKNOWN = 2'd2;

    localparam logic [0:0] ACTION_BYTE   = 1'b0;
    localparam logic [0:0] ACTION_SAMPLE = 1'b1;

    // Phrase indices, highest priority first
    localparam logic [3:0] PH_ALL_ON   = 4'd0;
    localparam logic [3:0] PH_ALL_OFF  = 4'd1;
    localparam logic [3:0] PH_L1_ON    = 4'd2;
    localparam logic [3:0] PH_L1_OFF   = 4'd3;
    localparam logic [3:0] PH_L2_ON    = 4'd4;
    localparam logic [3:0] PH_L2_OFF   = 4'd5;
    localparam logic [3:0] PH_L3_ON    = 4'd6;
    localparam logic [3:0] PH_L3_OFF   = 4'd7;
    localparam logic [3:0] PH_LDR_ON   = 4'd8;

    // Right-justified: byte j of an entry is the character j places back
    // from the newest one.
    localparam logic [WINDOW*8-1:0] PHRASE_STR [NUM_PHRASES] = '{
        "all lights on", "all lights off",
        "light 1 on", "light 1 off",
        "light 2 on", "light 2 off",
        "light 3 on", "light 3 off",
        "ldr on"
    };
    localparam int unsigned PHRASE_LEN [NUM_PHRASES] = '{
        13, 14, 10, 11, 10, 11, 10, 11, 6
    };

    typedef struct packed {
        logic [0:0] action;
        logic [7:0] rx_byte;
        logic [9:0] light_sample;
    } in_item_t;

    typedef struct packed {
        logic [2:0] lights;
        logic [2:0] manual_mask;
        logic [1:0] line_outcome;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

### rtl/core/tcl_char_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcl_char_cell
// One character slot of the search window; hands its byte on when shifted.
// ----------------------------------------------------------------------------
module tcl_char_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcl_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         char_in,
    output logic [7:0]         char_out
);

    logic [7:0] char_reg;
    logic [7:0] char_next;

    always_comb begin
        char_next = char_reg;
        if (ctrl.clear) begin
            char_next = tcl_pkg::CHAR_NUL;
        end else if (ctrl.shift) begin
            char_next = char_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_reg <= tcl_pkg::CHAR_NUL;
        end else begin
            char_reg <= char_next;
        end
    end

    assign char_out = char_reg;

endmodule

### rtl/core/tcl_phrase_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcl_phrase_window
// Chain of character cells plus the fixed-phrase comparators on the window
// as it will stand after the incoming character is shifted in.
// ----------------------------------------------------------------------------
module tcl_phrase_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcl_pkg::cell_ctrl_t                 ctrl,
    input  logic [7:0]                          char_in,
    output logic [tcl_pkg::NUM_PHRASES-1:0]     hits
);

    localparam int unsigned NumCells = tcl_pkg::WINDOW - 1;

    // Only WINDOW-1 cells are kept: the oldest slot of the window after a
    // shift is the old content of the last cell here.
    logic [7:0] cell_q   [NumCells];
    logic [7:0] win_next [tcl_pkg::WINDOW];

    genvar k;
    generate
        for (k = 0; k < NumCells; k++) begin : g_cell
            if (k == 0) begin : g_head
                tcl_char_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctrl     (ctrl),
                    .char_in  (char_in),
                    .char_out (cell_q[k])
                );
            end else begin : g_body
                tcl_char_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctrl     (ctrl),
                    .char_in  (cell_q[k-1]),
                    .char_out (cell_q[k])
                );
            end
        end
    endgenerate

    always_comb begin
        win_next[0] = char_in;
        for (int j = 1; j < tcl_pkg::WINDOW; j++) begin
            win_next[j] = cell_q[j-1];
        end
    end

    always_comb begin
        for (int p = 0; p < tcl_pkg::NUM_PHRASES; p++) begin
            hits[p] = 1'b1;
            for (int j = 0; j < tcl_pkg::WINDOW; j++) begin
                if (j < tcl_pkg::PHRASE_LEN[p] &&
                    win_next[j] != tcl_pkg::PHRASE_STR[p][8*j +: 8]) begin
                    hits[p] = 1'b0;
                end
            end
        end
    end

endmodule

### rtl/core/text_command_light_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_light_controller
// Gathers serial bytes into command lines, searches them for fixed phrases
// and drives three lights with manual override and dark-following.
// ----------------------------------------------------------------------------
//  channel   | ports                        | moves
//  ----------+------------------------------+---------------------------------
//  input     | s_valid s_ready s_data       | serial byte or light sample
//  result    | m_valid m_ready m_data       | lights, overrides, line outcome
//  config    | cfg_valid cfg_ready cfg_data | dark threshold (always ready)
//
//  One item per cycle while s_ready is high: each transfer updates all
//  line and light state, the phrase compare running on the cell chain as
//  the byte shifts in. A result is registered into the output register.
//  Two result slots (output register and skid) so s_ready only drops after
//  two results have stalled. No clearing pass after reset.
// ----------------------------------------------------------------------------
module text_command_light_controller #(
    parameter int unsigned LINE_CAPACITY = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tcl_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tcl_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcl_pkg::THR_W-1:0]         cfg_data
);

    localparam int unsigned CountW = $clog2(LINE_CAPACITY);
    localparam logic [CountW-1:0] CountMax = CountW'(LINE_CAPACITY - 1);

    logic [tcl_pkg::THR_W-1:0]       thr_reg;
    logic [2:0]                      light_reg, light_next;
    logic [2:0]                      manual_reg, manual_next;
    logic                            dark_reg, dark_next;
    logic [CountW-1:0]               count_reg, count_next;
    logic                            ended_reg, ended_next;
    logic [tcl_pkg::NUM_PHRASES-1:0] seen_reg, seen_next;

    tcl_pkg::out_item_t out_reg, skid_reg, result;
    logic               out_valid_reg, skid_valid_reg;

    logic                            s_fire, m_fire;
    logic                            is_byte, is_eol, finish, store, push;
    logic [7:0]                      folded;
    logic [tcl_pkg::NUM_PHRASES-1:0] hits;
    logic [3:0]                      hit_idx;
    logic                            hit_found;
    logic [2:0]                      lit_cmd;
    tcl_pkg::cell_ctrl_t             cell_ctrl;

    assign s_ready   = !skid_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign m_fire    = out_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    // Item decode
    always_comb begin
        folded = s_data.rx_byte;
        if (s_data.rx_byte inside {["A":"Z"]}) begin
            folded = s_data.rx_byte + tcl_pkg::CASE_STEP;
        end
        is_byte = (s_data.action == tcl_pkg::ACTION_BYTE);
        is_eol  = is_byte && (s_data.rx_byte == tcl_pkg::CHAR_CR ||
                              s_data.rx_byte == tcl_pkg::CHAR_LF);
        finish  = is_eol && (count_reg != '0);
        store   = is_byte && !is_eol && (count_reg != CountMax);
        push    = store && !ended_reg && (s_data.rx_byte != tcl_pkg::CHAR_NUL);
    end

    assign cell_ctrl.shift = s_fire && push;
    assign cell_ctrl.clear = s_fire && finish;

    tcl_phrase_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cell_ctrl),
        .char_in (folded),
        .hits    (hits)
    );

    // First phrase seen, in priority order
    always_comb begin
        hit_idx = tcl_pkg::PH_LDR_ON;
        for (int p = tcl_pkg::NUM_PHRASES - 1; p >= 0; p--) begin
            if (seen_reg[p]) begin
                hit_idx = 4'(p);
            end
        end
        hit_found = |seen_reg;
    end

    always_comb begin
        count_next  = count_reg;
        ended_next  = ended_reg;
        seen_next   = seen_reg;
        dark_next   = dark_reg;
        manual_next = manual_reg;
        lit_cmd     = light_reg;
        result      = '0;

        if (s_data.action == tcl_pkg::ACTION_SAMPLE) begin
            dark_next = ({1'b0, s_data.light_sample} < thr_reg);
        end
        if (store) begin
            count_next = count_reg + 1'b1;
            if (!ended_reg && s_data.rx_byte == tcl_pkg::CHAR_NUL) begin
                ended_next = 1'b1;
            end
        end
        if (push) begin
            seen_next = seen_reg | hits;
        end
        if (finish) begin
            count_next = '0;
            ended_next = 1'b0;
            seen_next  = '0;
            if (hit_found) begin
                case (hit_idx)
                    tcl_pkg::PH_ALL_ON: begin
                        lit_cmd = 3'b111; manual_next = 3'b111;
                    end
                    tcl_pkg::PH_ALL_OFF: begin
                        lit_cmd = 3'b000; manual_next = 3'b111;
                    end
                    tcl_pkg::PH_L1_ON: begin
                        lit_cmd = light_reg | 3'b001; manual_next = manual_reg | 3'b001;
                    end
                    tcl_pkg::PH_L1_OFF: begin
                        lit_cmd = light_reg & 3'b110; manual_next = manual_reg | 3'b001;
                    end
                    tcl_pkg::PH_L2_ON: begin
                        lit_cmd = light_reg | 3'b010; manual_next = manual_reg | 3'b010;
                    end
                    tcl_pkg::PH_L2_OFF: begin
                        lit_cmd = light_reg & 3'b101; manual_next = manual_reg | 3'b010;
                    end
                    tcl_pkg::PH_L3_ON: begin
                        lit_cmd = light_reg | 3'b100; manual_next = manual_reg | 3'b100;
                    end
                    tcl_pkg::PH_L3_OFF: begin
                        lit_cmd = light_reg & 3'b011; manual_next = manual_reg | 3'b100;
                    end
                    default: begin
                        manual_next = '0;
                    end
                endcase
                result.line_outcome = tcl_pkg::OUTCOME_RECOG;
            end else begin
                result.line_outcome = tcl_pkg::OUTCOME_UNKNOWN;
            end
        end else begin
            result.line_outcome = tcl_pkg::OUTCOME_NONE;
        end

        // lights without override follow the dark flag
        light_next = (lit_cmd & manual_next) | ({3{dark_next}} & ~manual_next);
        result.lights      = light_next;
        result.manual_mask = manual_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= tcl_pkg::THRESHOLD_RESET;
            light_reg  <= '0;
            manual_reg <= '0;
            dark_reg   <= 1'b1;
            count_reg  <= '0;
            ended_reg  <= 1'b0;
            seen_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (s_fire) begin
                light_reg  <= light_next;
                manual_reg <= manual_next;
                dark_reg   <= dark_next;
                count_reg  <= count_next;
                ended_reg  <= ended_next;
                seen_reg   <= seen_next;
            end
        end
    end

    // Result register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_fire) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_fire;
            end
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_fire) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_fire) begin
                out_reg <= result;
            end
        end else if (s_fire) begin
            skid_reg <= result;
        end
    end

endmodule

### rtl/core/tcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks on the text command light controller.
// ----------------------------------------------------------------------------
module tcl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tcl_pkg::out_item_t m_data
);

    // held result stays put until its transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.line_outcome == tcl_pkg::OUTCOME_NONE ||
                     m_data.line_outcome == tcl_pkg::OUTCOME_RECOG ||
                     m_data.line_outcome == tcl_pkg::OUTCOME_UNKNOWN))
        else $error("bad line outcome code");

    // lights without override all share the dark flag
    a_auto_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.lights & ~m_data.manual_mask) == 3'b000 ||
                     (m_data.lights | m_data.manual_mask) == 3'b111))
        else $error("auto lights disagree");

    // input only backs up once a result is waiting
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not ready after reset");

endmodule

bind text_command_light_controller tcl_checker u_tcl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
